>>> hdl/ucfd_pkg.sv
package ucfd_pkg;

	// register indexes of the configuration port
	localparam logic REG_START_BYTE = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	// register reset values
	localparam logic [7:0] START_BYTE_RESET = 8'd254;
	localparam logic [7:0] MAX_LENGTH_RESET = 8'd250;

	// subsystem field of command byte 0
	localparam logic [7:0] SUBSYS_MASK = 8'h1F;

	// deframer phases
	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_LEN     = 6'b000010,
		PH_CMD0    = 6'b000100,
		PH_CMD1    = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CHECK   = 6'b100000
	} phase_t;

endpackage

>>> hdl/uart_command_frame_deframer.sv
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------------------------
// in       | in_valid  | in_stall  | rx_byte
// out      | out_valid | out_stall | subsystem, command_id, payload_length,
//          |           |           | payload_byte, byte_index, is_end, fcs_ok
// cfg      | cfg_we    | -         | cfg_index, cfg_data
//
// One byte per cycle unless in_stall is high: a byte is registered, then the frame
// state updates and the result register loads when that byte advances.
// Reset clears the phase (hunting), frame state and both registers to their
// defaults. A held result stalls the input register only when the byte behind it
// also produces a result; bytes that produce nothing keep flowing.
module uart_command_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] subsystem,
	output logic [7:0] command_id,
	output logic [7:0] payload_length,
	output logic [7:0] payload_byte,
	output logic [7:0] byte_index,
	output logic       is_end,
	output logic       fcs_ok,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] start_byte_q;
	logic [7:0] max_length_q;

	logic       valid_s1;
	logic [7:0] byte_s1;

	ucfd_pkg::phase_t phase_q;
	ucfd_pkg::phase_t phase_d;
	logic [7:0] frame_length_q;
	logic [4:0] frame_subsystem_q;
	logic [7:0] frame_command_q;
	logic [7:0] bytes_seen_q;
	logic [7:0] check_accum_q;
	logic [7:0] seen_inc;

	logic produces;
	logic out_free;
	logic advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= ucfd_pkg::START_BYTE_RESET;
			max_length_q <= ucfd_pkg::MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ucfd_pkg::REG_START_BYTE: start_byte_q <= cfg_data;
				ucfd_pkg::REG_MAX_LENGTH: max_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a registered word yields a result only in payload and check phases
	assign produces = (phase_q == ucfd_pkg::PH_PAYLOAD) || (phase_q == ucfd_pkg::PH_CHECK);
	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && (!produces || out_free);
	assign in_stall = valid_s1 && !advance;
	assign seen_inc = bytes_seen_q + 8'd1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// next phase
	always_comb begin
		phase_d = ucfd_pkg::PH_HUNT;
		unique case (phase_q)
			ucfd_pkg::PH_LEN:
				phase_d = (byte_s1 > max_length_q) ? ucfd_pkg::PH_HUNT : ucfd_pkg::PH_CMD0;
			ucfd_pkg::PH_CMD0:
				phase_d = ucfd_pkg::PH_CMD1;
			ucfd_pkg::PH_CMD1:
				phase_d = (frame_length_q == 8'd0) ? ucfd_pkg::PH_CHECK : ucfd_pkg::PH_PAYLOAD;
			ucfd_pkg::PH_PAYLOAD:
				phase_d = (seen_inc >= frame_length_q) ? ucfd_pkg::PH_CHECK
					: ucfd_pkg::PH_PAYLOAD;
			ucfd_pkg::PH_CHECK:
				phase_d = ucfd_pkg::PH_HUNT;
			default:
				phase_d = (byte_s1 == start_byte_q) ? ucfd_pkg::PH_LEN : ucfd_pkg::PH_HUNT;
		endcase
	end

	// frame state, advanced once per consumed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= ucfd_pkg::PH_HUNT;
			frame_length_q    <= 8'd0;
			frame_subsystem_q <= 5'd0;
			frame_command_q   <= 8'd0;
			bytes_seen_q      <= 8'd0;
			check_accum_q     <= 8'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			case (phase_q)
				ucfd_pkg::PH_LEN: begin
					frame_length_q <= byte_s1;
					check_accum_q  <= byte_s1;
					bytes_seen_q   <= 8'd0;
				end
				ucfd_pkg::PH_CMD0: begin
					frame_subsystem_q <= 5'(byte_s1 & ucfd_pkg::SUBSYS_MASK);
					check_accum_q     <= check_accum_q ^ byte_s1;
				end
				ucfd_pkg::PH_CMD1: begin
					frame_command_q <= byte_s1;
					check_accum_q   <= check_accum_q ^ byte_s1;
					bytes_seen_q    <= 8'd0;
				end
				ucfd_pkg::PH_PAYLOAD: begin
					check_accum_q <= check_accum_q ^ byte_s1;
					bytes_seen_q  <= seen_inc;
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && produces) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			subsystem      <= frame_subsystem_q;
			command_id     <= frame_command_q;
			payload_length <= frame_length_q;
			if (phase_q == ucfd_pkg::PH_CHECK) begin
				payload_byte <= 8'd0;
				byte_index   <= 8'd0;
				is_end       <= 1'b1;
				fcs_ok       <= (byte_s1 == check_accum_q);
			end else begin
				payload_byte <= byte_s1;
				byte_index   <= bytes_seen_q;
				is_end       <= 1'b0;
				fcs_ok       <= 1'b0;
			end
		end
	end

	// checks
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_end |-> payload_byte == 8'd0 && byte_index == 8'd0)
		else $error("end word carries payload data");

	a_ok_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_end |-> !fcs_ok && byte_index < payload_length)
		else $error("payload word malformed");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && produces && out_valid && out_stall)
		else $error("input stalled without a held result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(is_end))
		else $error("held result lost or overwritten");

endmodule

>>> tb/sv/deframer_tb_pkg.sv
`timescale 1ns / 100ps

package deframer_tb_pkg;
	import ucfd_pkg::*;

	// one output word of the deframer
	typedef struct packed {
		logic [4:0] subsystem;
		logic [7:0] command_id;
		logic [7:0] payload_length;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic       is_end;
		logic       fcs_ok;
	} frame_word_t;

	class frame_scoreboard;
		logic [7:0]  start_byte;
		logic [7:0]  max_length;
		phase_t      phase;
		logic [7:0]  frame_len;
		logic [4:0]  frame_sub;
		logic [7:0]  frame_cmd;
		logic [7:0]  seen;
		logic [7:0]  accum;
		frame_word_t expected_words[$];
		int          errors;
		int          words_checked;

		function new();
			start_byte    = START_BYTE_RESET;
			max_length    = MAX_LENGTH_RESET;
			phase         = PH_HUNT;
			frame_len     = 8'd0;
			frame_sub     = 5'd0;
			frame_cmd     = 8'd0;
			seen          = 8'd0;
			accum         = 8'd0;
			errors        = 0;
			words_checked = 0;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		// mirror a register write
		function void write_register(logic idx, logic [7:0] value);
			if (idx == REG_START_BYTE)
				start_byte = value;
			else if (idx == REG_MAX_LENGTH)
				max_length = value;
		endfunction

		// advance the frame state by one accepted byte, queue any word it yields
		function void note_byte(logic [7:0] b);
			frame_word_t w;
			logic [7:0]  masked;
			w.subsystem      = frame_sub;
			w.command_id     = frame_cmd;
			w.payload_length = frame_len;
			w.payload_byte   = 8'd0;
			w.byte_index     = 8'd0;
			w.is_end         = 1'b0;
			w.fcs_ok         = 1'b0;
			case (phase)
			PH_LEN: begin
				frame_len = b;
				accum     = b;
				seen      = 8'd0;
				phase     = (b > max_length) ? PH_HUNT : PH_CMD0;
			end
			PH_CMD0: begin
				masked    = b & SUBSYS_MASK;
				frame_sub = masked[4:0];
				accum     = accum ^ b;
				phase     = PH_CMD1;
			end
			PH_CMD1: begin
				frame_cmd = b;
				accum     = accum ^ b;
				seen      = 8'd0;
				phase     = (frame_len == 8'd0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				w.payload_byte = b;
				w.byte_index   = seen;
				expected_words.push_back(w);
				accum = accum ^ b;
				seen  = seen + 8'd1;
				if (seen >= frame_len)
					phase = PH_CHECK;
			end
			PH_CHECK: begin
				w.is_end = 1'b1;
				w.fcs_ok = (b == accum);
				expected_words.push_back(w);
				phase = PH_HUNT;
			end
			default: begin
				phase = (b == start_byte) ? PH_LEN : PH_HUNT;
			end
			endcase
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_field(string field, logic [7:0] want, logic [7:0] seen_val);
			if (seen_val !== want)
				report($sformatf("word %0d %s: expected %h, got %h",
					words_checked, field, want, seen_val));
		endtask

		// compare an accepted word with the oldest expected one
		task check_word(frame_word_t got);
			frame_word_t want;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word %0d: payload_byte %h is_end %b",
					words_checked, got.payload_byte, got.is_end));
			end else begin
				want = expected_words.pop_front();
				check_field("subsystem", {3'd0, want.subsystem}, {3'd0, got.subsystem});
				check_field("command_id", want.command_id, got.command_id);
				check_field("payload_length", want.payload_length, got.payload_length);
				check_field("payload_byte", want.payload_byte, got.payload_byte);
				check_field("byte_index", want.byte_index, got.byte_index);
				check_field("is_end", {7'd0, want.is_end}, {7'd0, got.is_end});
				check_field("fcs_ok", {7'd0, want.fcs_ok}, {7'd0, got.fcs_ok});
			end
			words_checked++;
		endtask
	endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ucfd_pkg::*;
	import deframer_tb_pkg::*;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [4:0] subsystem;
	logic [7:0] command_id;
	logic [7:0] payload_length;
	logic [7:0] payload_byte;
	logic [7:0] byte_index;
	logic       is_end;
	logic       fcs_ok;
	logic       cfg_we    = 1'b0;
	logic       cfg_index = REG_START_BYTE;
	logic [7:0] cfg_data  = 8'h00;

	frame_scoreboard sb = new();
	logic [7:0]      tx_queue[$];
	int              tx_calm     = 0;
	int              rx_calm     = 0;
	int              rx_hold_req = 0;
	int              phase_bytes = 0;

	always #5 clk = ~clk;

	uart_command_frame_deframer dut (.*);

	// draw a wait in cycles, with occasional stretches of back-to-back words
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 18);
	endfunction

	// mostly short payloads, now and then up to the limit
	function automatic logic [7:0] pick_length();
		int cap;
		if ($urandom_range(0, 39) == 0)
			return 8'($urandom_range(0, sb.max_length));
		cap = (sb.max_length < 8) ? sb.max_length : 8;
		return 8'($urandom_range(0, cap));
	endfunction

	// build a whole frame, optionally with a bad check byte
	function automatic void queue_frame(logic [7:0] len, logic [7:0] c0, logic [7:0] c1,
			bit corrupt, bit start_fill);
		logic [7:0] fcs;
		logic [7:0] d;
		int         i;
		tx_queue.push_back(sb.start_byte);
		tx_queue.push_back(len);
		tx_queue.push_back(c0);
		tx_queue.push_back(c1);
		fcs = len ^ c0 ^ c1;
		for (i = 0; i < len; i++) begin
			if (start_fill || $urandom_range(0, 7) == 0)
				d = sb.start_byte;
			else
				d = 8'($urandom_range(0, 255));
			tx_queue.push_back(d);
			fcs = fcs ^ d;
		end
		if (corrupt)
			fcs = fcs ^ 8'($urandom_range(1, 255));
		tx_queue.push_back(fcs);
	endfunction

	// offer one word and hold it until taken
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = draw_wait(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_byte(b);
		phase_bytes++;
	endtask

	task automatic send_queued();
		while (tx_queue.size() > 0)
			send_byte(tx_queue.pop_front());
	endtask

	// stop sending and wait for every expected word, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_register(idx, value);
		@(posedge clk);
	endtask

	// mix of frames (some with a bad check byte), oversized headers, cut-off frames and noise
	task automatic random_traffic(int budget);
		int pick;
		int k;
		phase_bytes = 0;
		while (phase_bytes < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				queue_frame(pick_length(), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0);
			end else if (pick < 80) begin
				if (sb.max_length != 8'hFF) begin
					tx_queue.push_back(sb.start_byte);
					tx_queue.push_back(8'($urandom_range(int'(sb.max_length) + 1, 255)));
				end
				queue_frame(pick_length(), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end else if (pick < 90) begin
				queue_frame(pick_length(), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'b0, 1'b0);
				k = $urandom_range(2, 4);
				while (tx_queue.size() > k)
					void'(tx_queue.pop_back());
			end else begin
				k = $urandom_range(1, 4);
				repeat (k) tx_queue.push_back(8'($urandom_range(0, 255)));
			end
			send_queued();
		end
	endtask

	// drain result words with random stalls and one long hold-off on request
	initial begin : result_sink
		int          n;
		frame_word_t got;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req > 0) begin
				n = rx_hold_req;
				rx_hold_req = 0;
			end else begin
				n = draw_wait(rx_calm);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got = {subsystem, command_id, payload_length, payload_byte, byte_index,
				is_end, fcs_ok};
			sb.check_word(got);
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int         p;
		logic [7:0] new_start;
		logic [7:0] new_max;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: noise, empty payload, subsystem mask with bad check,
		// oversized length followed at once by a frame full of start bytes
		tx_queue.push_back(8'h00);
		tx_queue.push_back(8'hFF);
		queue_frame(8'd0, 8'h00, 8'hFF, 1'b0, 1'b0);
		queue_frame(8'd1, 8'hFF, 8'h00, 1'b1, 1'b0);
		tx_queue.push_back(sb.start_byte);
		tx_queue.push_back(sb.max_length + 8'd1);
		queue_frame(8'd2, sb.start_byte, sb.start_byte, 1'b0, 1'b1);
		send_queued();

		// hold the result side off while words keep coming back to back
		drain();
		rx_hold_req = 400;
		tx_calm     = 60;
		repeat (6) queue_frame(8'd8, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			1'b0, 1'b0);
		send_queued();
		random_traffic(220);

		// step through register settings, extremes first
		for (p = 1; p <= 5; p++) begin
			case (p)
			1: begin
				new_start = 8'h00;
				new_max   = 8'h00;
			end
			2: begin
				new_start = 8'hFF;
				new_max   = 8'hFF;
			end
			3: begin
				new_start = 8'($urandom_range(0, 255));
				new_max   = 8'($urandom_range(1, 16));
			end
			default: begin
				new_start = 8'($urandom_range(0, 255));
				new_max   = 8'($urandom_range(0, 255));
			end
			endcase
			drain();
			write_reg(REG_START_BYTE, new_start);
			write_reg(REG_MAX_LENGTH, new_max);
			if (p == 2) begin
				queue_frame(8'd255, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'b0, 1'b0);
				send_queued();
			end
			random_traffic(220);
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
hdl/ucfd_pkg.sv
hdl/uart_command_frame_deframer.sv
tb/sv/deframer_tb_pkg.sv
tb/sv/tb_top.sv
